[hw/rtl/dkpq_pkg.sv]
// Shared types, constants and helpers of the date keyed priority queue.
`timescale 1ns / 1ps

package dkpq_pkg;

  // Queue size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Date arithmetic
  localparam int DAYS_PER_MONTH = 30;
  localparam int MONTHS         = 12;
  localparam int CATEGORY_NONE  = 6;

  // Configuration register indexes
  localparam logic CFG_TODAY_MONTH = 1'b0;
  localparam logic CFG_TODAY_DAY   = 1'b1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_CAT    = 2'd2,
    ACT_WINDOW = 2'd3
  } action_e;

  typedef struct packed {
    logic [2:0]  category;
    logic [7:0]  item_number;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] handle;
  } entry_t;

  typedef struct packed {
    action_e     action;
    logic [2:0]  category;
    logic [7:0]  item_number;
    logic [3:0]  due_month;
    logic [4:0]  due_day;
    logic [15:0] description_handle;
    logic        description_empty;
    logic [9:0]  window_days;
  } item_t;

  // Scan index update
  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_ZERO = 3'd1,
    IDX_TOP  = 3'd2,
    IDX_INC  = 3'd3,
    IDX_DEC  = 3'd4
  } idx_op_e;

  // Store write select
  typedef enum logic [1:0] {
    W_NONE    = 2'd0,
    W_NEW_IDX = 2'd1,
    W_RD_INC  = 2'd2,
    W_RD_DEC  = 2'd3
  } wr_op_e;

  typedef struct packed {
    logic    start;
    idx_op_e idx_op;
    logic    rd;
    wr_op_e  wr_op;
    logic    hold_load;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    ins_ok_set;
    logic    emit_mid;
    logic    emit_final;
  } dp_cmd_t;

  typedef struct packed {
    action_e action;
    logic    ins_bad;
    logic    q_empty;
    logic    key_gt;
    logic    idx_zero;
    logic    idx_last;
    logic    cat_match;
    logic    in_window;
    logic    hold_valid;
    logic    out_free;
  } dp_stat_t;

  // Date key (month-1)*30+day, valid months give at most 361
  function automatic logic [8:0] date_key(input logic [3:0] month, input logic [4:0] day);
    date_key = (9'(month) - 9'd1) * 9'(DAYS_PER_MONTH) + 9'(day);
  endfunction

endpackage

[hw/rtl/dkpq_req_if.sv]
// Request channel: one queue operation per beat.
`timescale 1ns / 1ps

interface dkpq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  category;
  logic [7:0]  item_number;
  logic [3:0]  due_month;
  logic [4:0]  due_day;
  logic [15:0] description_handle;
  logic        description_empty;
  logic [9:0]  window_days;

  modport source (output valid, action, category, item_number, due_month, due_day,
                  description_handle, description_empty, window_days, input ready);
  modport sink (input valid, action, category, item_number, due_month, due_day,
                description_handle, description_empty, window_days, output ready);
endinterface

[hw/rtl/dkpq_rsp_if.sv]
// Response channel: one result per beat.
`timescale 1ns / 1ps

interface dkpq_rsp_if;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [2:0]        out_category;
  logic [7:0]        out_item_number;
  logic [3:0]        out_month;
  logic [4:0]        out_day;
  logic [15:0]       out_handle;
  logic signed [9:0] days_left;
  logic              last;

  modport source (output valid, ok, out_category, out_item_number, out_month, out_day,
                  out_handle, days_left, last, input ready);
  modport sink (input valid, ok, out_category, out_item_number, out_month, out_day,
                out_handle, days_left, last, output ready);
endinterface

[hw/rtl/dkpq_cfg_if.sv]
// Configuration write channel: register index and data per beat.
`timescale 1ns / 1ps

interface dkpq_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [4:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/dkpq_ram.sv]
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module dkpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/dkpq_ctrl.sv]
// Operation sequencer: walks the store for insert, pop and queries.
`timescale 1ns / 1ps

module dkpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dkpq_pkg::dp_stat_t stat,
  output dkpq_pkg::dp_cmd_t  cmd
);
  import dkpq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_INS_SCAN = 6'b000100,
    S_INS_PUT  = 6'b001000,
    S_FWD_SCAN = 6'b010000,
    S_FINAL    = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   stall;
  logic   done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window match must wait for the output register before replacing hold
  assign stall = (stat.action == ACT_WINDOW) && stat.in_window && stat.hold_valid &&
                 !stat.out_free;
  assign done  = stat.idx_last || ((stat.action == ACT_CAT) && stat.cat_match);

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        if (stat.action == ACT_INSERT) begin
          if (stat.ins_bad) begin
            state_next = S_FINAL;
          end else if (stat.q_empty) begin
            cmd.idx_op = IDX_ZERO;
            state_next = S_INS_PUT;
          end else begin
            cmd.idx_op = IDX_TOP;
            cmd.rd     = 1'b1;
            state_next = S_INS_SCAN;
          end
        end else if (stat.q_empty) begin
          state_next = S_FINAL;
        end else begin
          cmd.idx_op = IDX_ZERO;
          cmd.rd     = 1'b1;
          state_next = S_FWD_SCAN;
        end
      end

      // walk down from the tail, moving larger keys up one place
      S_INS_SCAN: begin
        if (stat.key_gt) begin
          cmd.wr_op = W_RD_INC;
          if (stat.idx_zero) begin
            state_next = S_INS_PUT;
          end else begin
            cmd.idx_op = IDX_DEC;
            cmd.rd     = 1'b1;
          end
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        cmd.wr_op      = W_NEW_IDX;
        cmd.cnt_inc    = 1'b1;
        cmd.ins_ok_set = 1'b1;
        state_next     = S_FINAL;
      end

      // walk up from the head for pop and both queries
      S_FWD_SCAN: begin
        if (!stall) begin
          unique case (stat.action)
            ACT_POP: begin
              if (stat.idx_zero) begin
                cmd.hold_load = 1'b1;
              end else begin
                cmd.wr_op = W_RD_DEC;
              end
              cmd.cnt_dec = stat.idx_last;
            end
            ACT_CAT: begin
              cmd.hold_load = stat.cat_match;
            end
            ACT_WINDOW: begin
              cmd.hold_load = stat.in_window;
              cmd.emit_mid  = stat.in_window && stat.hold_valid;
            end
            default: begin
            end
          endcase
          if (done) begin
            state_next = S_FINAL;
          end else begin
            cmd.idx_op = IDX_INC;
            cmd.rd     = 1'b1;
          end
        end
      end

      S_FINAL: begin
        if (stat.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/dkpq_dp.sv]
// Datapath: entry store, scan index, fill count, hold and result registers.
`timescale 1ns / 1ps

module dkpq_dp (
  input  logic               clk,
  input  logic               rst,
  input  dkpq_pkg::item_t    item_in,
  input  dkpq_pkg::dp_cmd_t  cmd,
  output dkpq_pkg::dp_stat_t stat,
  dkpq_cfg_if.sink           cfg,
  dkpq_rsp_if.source         rsp
);
  import dkpq_pkg::*;

  item_t             item;
  logic [3:0]        today_month_index;
  logic [4:0]        today_day;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  idx, idx_next;
  entry_t            hold;
  logic              hold_valid;
  logic              ins_ok;

  entry_t            new_entry, rdata, wdata;
  logic              we;
  logic [IDX_W-1:0]  waddr;

  logic [9:0]        today_key;
  logic [8:0]        new_key, rd_key, hold_key;
  logic [10:0]       win_lo, win_hi, rd_key_x;
  logic [10:0]       hold_diff;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      today_month_index <= 4'd0;
      today_day         <= 5'd1;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == CFG_TODAY_MONTH) begin
        today_month_index <= cfg.data[3:0];
      end else begin
        today_day <= cfg.data;
      end
    end
  end

  // operation register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item <= item_in;
    end
  end

  assign new_entry = '{category: item.category, item_number: item.item_number,
                       month: item.due_month, day: item.due_day,
                       handle: item.description_handle};

  // keys and window bounds
  assign today_key = 10'(today_month_index) * 10'(DAYS_PER_MONTH) + 10'(today_day);
  assign new_key   = date_key(item.due_month, item.due_day);
  assign rd_key    = date_key(rdata.month, rdata.day);
  assign hold_key  = date_key(hold.month, hold.day);
  assign rd_key_x  = {2'b00, rd_key};
  assign win_lo    = {1'b0, today_key};
  assign win_hi    = win_lo + {1'b0, item.window_days};
  assign hold_diff = {2'b00, hold_key} - win_lo;

  // scan index
  assign cnt_m1 = count - CNT_W'(1);
  always_comb begin
    unique case (cmd.idx_op)
      IDX_ZERO: idx_next = '0;
      IDX_TOP:  idx_next = cnt_m1[IDX_W-1:0];
      IDX_INC:  idx_next = idx + IDX_W'(1);
      IDX_DEC:  idx_next = idx - IDX_W'(1);
      default:  idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      count <= '0;
    end else begin
      idx <= idx_next;
      if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= cnt_m1;
      end
    end
  end

  // store write select
  always_comb begin
    we    = 1'b1;
    waddr = idx;
    wdata = rdata;
    unique case (cmd.wr_op)
      W_NEW_IDX: wdata = new_entry;
      W_RD_INC:  waddr = idx + IDX_W'(1);
      W_RD_DEC:  waddr = idx - IDX_W'(1);
      default:   we = 1'b0;
    endcase
  end

  dkpq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (idx_next),
    .rdata (rdata)
  );

  // hold entry and insert status
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      ins_ok     <= 1'b0;
    end else if (cmd.start) begin
      hold_valid <= 1'b0;
      ins_ok     <= 1'b0;
    end else begin
      if (cmd.hold_load) begin
        hold_valid <= 1'b1;
      end
      if (cmd.ins_ok_set) begin
        ins_ok <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_load) begin
      hold <= rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.emit_mid || cmd.emit_final) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_mid) begin
      rsp.ok              <= 1'b1;
      rsp.out_category    <= hold.category;
      rsp.out_item_number <= hold.item_number;
      rsp.out_month       <= hold.month;
      rsp.out_day         <= hold.day;
      rsp.out_handle      <= hold.handle;
      rsp.days_left       <= $signed(hold_diff[9:0]);
      rsp.last            <= 1'b0;
    end else if (cmd.emit_final) begin
      rsp.ok              <= hold_valid || ins_ok;
      rsp.out_category    <= hold_valid ? hold.category : 3'd0;
      rsp.out_item_number <= hold_valid ? hold.item_number : 8'd0;
      rsp.out_month       <= hold_valid ? hold.month : 4'd0;
      rsp.out_day         <= hold_valid ? hold.day : 5'd0;
      rsp.out_handle      <= hold_valid ? hold.handle : 16'd0;
      rsp.days_left       <= (hold_valid && (item.action != ACT_POP)) ?
                             $signed(hold_diff[9:0]) : 10'sd0;
      rsp.last            <= 1'b1;
    end
  end

  // status to the sequencer
  always_comb begin
    stat.action     = item.action;
    stat.ins_bad    = (item.due_month == 4'd0) || (item.due_month > 4'(MONTHS)) ||
                      (item.due_day == 5'd0) || (item.category >= 3'(CATEGORY_NONE)) ||
                      item.description_empty || (count == CNT_W'(CAPACITY));
    stat.q_empty    = (count == '0);
    stat.key_gt     = rd_key > new_key;
    stat.idx_zero   = (idx == '0);
    stat.idx_last   = (CNT_W'(idx) == cnt_m1);
    stat.cat_match  = (rdata.category == item.category);
    stat.in_window  = (rd_key_x >= win_lo) && (rd_key_x < win_hi);
    stat.hold_valid = hold_valid;
    stat.out_free   = !rsp.valid || rsp.ready;
  end

endmodule

[hw/rtl/date_keyed_priority_queue.sv]
// Date keyed priority queue: sorted store of up to CAPACITY entries.
// One operation at a time. Insert walks down from the tail over the store's
// single read port; pop, category and window queries walk up from the head,
// one store read per entry. Rejected inserts and pops or queries on an empty
// queue skip the walk; a stalled rsp channel delays completion.
// Synchronous reset empties the queue and sets today to month index 0, day 1.
`timescale 1ns / 1ps

module date_keyed_priority_queue (
  input  logic       clk,
  input  logic       rst,
  dkpq_req_if.sink   req,
  dkpq_rsp_if.source rsp,
  dkpq_cfg_if.sink   cfg
);
  import dkpq_pkg::*;

  item_t    item_in;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  // request beat into the operation format
  assign item_in = '{action: action_e'(req.action), category: req.category,
                     item_number: req.item_number, due_month: req.due_month,
                     due_day: req.due_day, description_handle: req.description_handle,
                     description_empty: req.description_empty,
                     window_days: req.window_days};
  assign req.ready = in_ready;

  dkpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dkpq_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .item_in (item_in),
    .cmd     (cmd),
    .stat    (stat),
    .cfg     (cfg),
    .rsp     (rsp)
  );

endmodule

[test/date_keyed_priority_queue_tb.sv]
// Testbench for the date keyed priority queue: random and directed traffic, checked beat by beat.
`timescale 1ns / 1ps

module date_keyed_priority_queue_tb;
  import dkpq_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int HOLD_OFF    = 250;

  // One response beat as seen on the rsp channel
  typedef struct packed {
    logic              ok;
    logic [2:0]        category;
    logic [7:0]        item_number;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [15:0]       handle;
    logic signed [9:0] days_left;
    logic              last;
  } result_t;

  // Shadow copy of the sorted queue and the response beats it must produce
  class queue_mirror;
    entry_t      slots[CAPACITY];
    int          held;
    logic [3:0]  month_idx;
    logic [4:0]  day_of_month;
    result_t     awaited[$];
    int          errors;

    function new();
      held         = 0;
      month_idx    = 4'd0;
      day_of_month = 5'd1;
      errors       = 0;
    endfunction

    function int key_of(logic [3:0] m, logic [4:0] d);
      return (int'(m) - 1) * DAYS_PER_MONTH + int'(d);
    endfunction

    function int today_key();
      return int'(month_idx) * DAYS_PER_MONTH + int'(day_of_month);
    endfunction

    function void write_register(logic idx, logic [4:0] value);
      if (idx == CFG_TODAY_MONTH) month_idx = value[3:0];
      else day_of_month = value;
    endfunction

    // Status-only beat: insert outcome, empty queue, no match
    function void push_status(logic ok);
      result_t r;
      r      = '0;
      r.ok   = ok;
      r.last = 1'b1;
      awaited.push_back(r);
    endfunction

    function void push_entry(entry_t e, int diff, logic last);
      result_t r;
      r             = '0;
      r.ok          = 1'b1;
      r.category    = e.category;
      r.item_number = e.item_number;
      r.month       = e.month;
      r.day         = e.day;
      r.handle      = e.handle;
      r.days_left   = diff[9:0];
      r.last        = last;
      awaited.push_back(r);
    endfunction

    function void note_request(item_t it);
      entry_t  e;
      result_t r;
      int      pos;
      int      t;
      int      k;
      int      hits;
      logic    bad;
      t = today_key();
      case (it.action)
        ACT_INSERT: begin
          bad = it.due_month < 1 || it.due_month > MONTHS || it.due_day < 1 ||
                it.category >= CATEGORY_NONE || it.description_empty || held >= CAPACITY;
          if (bad) begin
            push_status(1'b0);
          end else begin
            e.category    = it.category;
            e.item_number = it.item_number;
            e.month       = it.due_month;
            e.day         = it.due_day;
            e.handle      = it.description_handle;
            // equal keys keep arrival order
            pos = 0;
            while (pos < held && key_of(slots[pos].month, slots[pos].day) <= key_of(e.month, e.day))
              pos++;
            for (int i = held; i > pos; i--) slots[i] = slots[i - 1];
            slots[pos] = e;
            held++;
            push_status(1'b1);
          end
        end
        ACT_POP: begin
          if (held == 0) begin
            push_status(1'b0);
          end else begin
            push_entry(slots[0], 0, 1'b1);
            for (int i = 1; i < held; i++) slots[i - 1] = slots[i];
            held--;
          end
        end
        ACT_CAT: begin
          pos = -1;
          for (int i = 0; i < held; i++)
            if (pos < 0 && slots[i].category == it.category) pos = i;
          if (pos < 0) push_status(1'b0);
          else push_entry(slots[pos], key_of(slots[pos].month, slots[pos].day) - t, 1'b1);
        end
        default: begin
          hits = 0;
          for (int i = 0; i < held; i++) begin
            k = key_of(slots[i].month, slots[i].day);
            if (k >= t && k < t + int'(it.window_days)) begin
              push_entry(slots[i], k - t, 1'b0);
              hits++;
            end
          end
          if (hits == 0) begin
            push_status(1'b0);
          end else begin
            r      = awaited.pop_back();
            r.last = 1'b1;
            awaited.push_back(r);
          end
        end
      endcase
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_beat;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %h", $time, got);
        errors++;
        return;
      end
      exp_beat = awaited.pop_front();
      compare_field("ok", exp_beat.ok, got.ok);
      compare_field("out_category", exp_beat.category, got.category);
      compare_field("out_item_number", exp_beat.item_number, got.item_number);
      compare_field("out_month", exp_beat.month, got.month);
      compare_field("out_day", exp_beat.day, got.day);
      compare_field("out_handle", exp_beat.handle, got.handle);
      compare_field("days_left", int'(exp_beat.days_left), int'(got.days_left));
      compare_field("last", exp_beat.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  queue_mirror mirror;
  int          cycle_count;
  bit          steady;
  int          rsp_hold_cycles;

  dkpq_req_if req_ch ();
  dkpq_rsp_if rsp_ch ();
  dkpq_cfg_if cfg_ch ();

  date_keyed_priority_queue i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic item_t make_item(action_e act, int cat, int num, int m, int d, int h,
                                      bit empty, int win);
    item_t it;
    it.action             = act;
    it.category           = 3'(cat);
    it.item_number        = 8'(num);
    it.due_month          = 4'(m);
    it.due_day            = 5'(d);
    it.description_handle = 16'(h);
    it.description_empty  = empty;
    it.window_days        = 10'(win);
    return it;
  endfunction

  // Mostly well-formed inserts and queries, some raw noise
  function automatic item_t random_item(int insert_pct);
    item_t it;
    int    r;
    it = make_item(ACT_INSERT, $urandom_range(0, 7), $urandom, $urandom_range(0, 15),
                   $urandom_range(0, 31), $urandom, $urandom_range(0, 1), $urandom_range(0, 1023));
    r = $urandom_range(0, 99);
    if (r < insert_pct) begin
      if ($urandom_range(0, 9) != 0) begin
        it.due_month         = 4'($urandom_range(1, MONTHS));
        it.due_day           = 5'($urandom_range(1, 31));
        it.category          = 3'($urandom_range(0, CATEGORY_NONE - 1));
        it.description_empty = 1'b0;
        // cluster some keys so ties show up
        if ($urandom_range(0, 3) == 0) begin
          it.due_month = 4'd3;
          it.due_day   = 5'($urandom_range(9, 11));
        end
      end
    end else begin
      r = $urandom_range(0, 2);
      it.action = (r == 0) ? ACT_POP : (r == 1) ? ACT_CAT : ACT_WINDOW;
      if (it.action == ACT_WINDOW && $urandom_range(0, 3) != 0)
        it.window_days = 10'($urandom_range(0, 240));
    end
    return it;
  endfunction

  // Offer one request beat, return once it is taken
  task automatic send_request(item_t it);
    int gap;
    gap = steady ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.action             = it.action;
    req_ch.category           = it.category;
    req_ch.item_number        = it.item_number;
    req_ch.due_month          = it.due_month;
    req_ch.due_day            = it.due_day;
    req_ch.description_handle = it.description_handle;
    req_ch.description_empty  = it.description_empty;
    req_ch.window_days        = it.window_days;
    req_ch.valid              = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stop offering and let every expected beat arrive
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(logic idx, logic [4:0] value);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_today(int month_idx, int day);
    write_config(CFG_TODAY_MONTH, 5'(month_idx));
    write_config(CFG_TODAY_DAY, 5'(day));
  endtask

  task automatic run_mix(int count, int insert_pct);
    for (int n = 0; n < count; n++) begin
      if (n % 16 == 0) steady = ($urandom_range(0, 3) == 0);
      send_request(random_item(insert_pct));
    end
    steady = 1'b0;
  endtask

  // Beat monitor: results checked before new requests are noted
  always @(posedge clk) begin : beat_monitor
    item_t   seen;
    result_t got;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) mirror.write_register(cfg_ch.index, cfg_ch.data);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.ok          = rsp_ch.ok;
        got.category    = rsp_ch.out_category;
        got.item_number = rsp_ch.out_item_number;
        got.month       = rsp_ch.out_month;
        got.day         = rsp_ch.out_day;
        got.handle      = rsp_ch.out_handle;
        got.days_left   = rsp_ch.days_left;
        got.last        = rsp_ch.last;
        mirror.check_result(got);
      end
      if (req_ch.valid && req_ch.ready) begin
        seen.action             = action_e'(req_ch.action);
        seen.category           = req_ch.category;
        seen.item_number        = req_ch.item_number;
        seen.due_month          = req_ch.due_month;
        seen.due_day            = req_ch.due_day;
        seen.description_handle = req_ch.description_handle;
        seen.description_empty  = req_ch.description_empty;
        seen.window_days        = req_ch.window_days;
        mirror.note_request(seen);
      end
    end
  end

  // Response side: random stalls plus the long hold-off on request
  initial begin : rsp_sink
    int stall;
    stall        = 0;
    rsp_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp_ch.ready = 1'b0;
        rsp_hold_cycles--;
      end else if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        stall--;
      end else begin
        rsp_ch.ready = 1'b1;
        if (!steady) stall = pick_gap();
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[date_keyed_priority_queue] ERROR");
    $finish;
  end

  // Main sequence
  initial begin
    mirror                    = new();
    steady                    = 1'b0;
    rsp_hold_cycles           = 0;
    rst                       = 1'b1;
    req_ch.valid              = 1'b0;
    req_ch.action             = ACT_INSERT;
    req_ch.category           = '0;
    req_ch.item_number        = '0;
    req_ch.due_month          = '0;
    req_ch.due_day            = '0;
    req_ch.description_handle = '0;
    req_ch.description_empty  = 1'b0;
    req_ch.window_days        = '0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.index              = CFG_TODAY_MONTH;
    cfg_ch.data               = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty queue, field extremes, every field reject reason, ties
    send_request(make_item(ACT_POP, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_item(ACT_CAT, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_item(ACT_WINDOW, 0, 0, 0, 0, 0, 0, 1023));
    send_request(make_item(ACT_INSERT, 5, 255, 12, 31, 16'hffff, 0, 0));
    send_request(make_item(ACT_INSERT, 0, 0, 1, 1, 0, 0, 0));
    send_request(make_item(ACT_INSERT, 2, 17, 3, 10, 16'h1234, 0, 0));
    send_request(make_item(ACT_INSERT, 3, 18, 3, 10, 16'h5678, 0, 0));
    send_request(make_item(ACT_INSERT, 1, 99, 2, 31, 16'h0f0f, 0, 0));
    send_request(make_item(ACT_INSERT, 1, 1, 0, 5, 1, 0, 0));
    send_request(make_item(ACT_INSERT, 1, 2, 13, 5, 2, 0, 0));
    send_request(make_item(ACT_INSERT, 1, 3, 15, 5, 3, 0, 0));
    send_request(make_item(ACT_INSERT, 1, 4, 4, 0, 4, 0, 0));
    send_request(make_item(ACT_INSERT, 6, 5, 4, 5, 5, 0, 0));
    send_request(make_item(ACT_INSERT, 7, 6, 4, 5, 6, 0, 0));
    send_request(make_item(ACT_INSERT, 1, 7, 4, 5, 7, 1, 0));
    send_request(make_item(ACT_CAT, 3, 0, 0, 0, 0, 0, 0));
    send_request(make_item(ACT_CAT, 6, 0, 0, 0, 0, 0, 0));
    send_request(make_item(ACT_CAT, 4, 0, 0, 0, 0, 0, 0));
    send_request(make_item(ACT_WINDOW, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_item(ACT_WINDOW, 0, 0, 0, 0, 0, 0, 1023));
    send_request(make_item(ACT_WINDOW, 0, 0, 0, 0, 0, 0, 70));
    send_request(make_item(ACT_POP, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_item(ACT_POP, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // Latest legal today; insert heavy so the queue fills and rejects
    set_today(MONTHS - 1, 31);
    run_mix(50, 70);
    wait_drained();

    // Receiver holds off while requests keep coming
    rsp_hold_cycles = HOLD_OFF;
    run_mix(30, 50);
    wait_drained();

    // Earliest today
    set_today(0, 1);
    run_mix(50, 40);
    wait_drained();

    // Register values outside the calendar
    set_today(15, 0);
    run_mix(40, 35);
    wait_drained();

    set_today($urandom_range(0, MONTHS - 1), $urandom_range(1, 31));
    run_mix(40, 45);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("[date_keyed_priority_queue] OK");
    end else begin
      $display("[date_keyed_priority_queue] ERROR");
    end
    $finish;
  end

endmodule
